FILE: hw/rtl/sprite_vm_instruction_core_defines.svh
// Assertion macros shared by the RTL of the sprite virtual machine core.
`ifndef SPRITE_VM_INSTRUCTION_CORE_DEFINES_SVH
`define SPRITE_VM_INSTRUCTION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/svm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int SCREEN_W  = 64;
    localparam int SCREEN_H  = 32;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROW_W     = $clog2(SCREEN_H);
    localparam int COL_W     = $clog2(SCREEN_W);

    // Action codes of an input beat.
    localparam logic [2:0] ACT_MEM_WRITE = 3'd0;
    localparam logic [2:0] ACT_MEM_READ  = 3'd1;
    localparam logic [2:0] ACT_EXECUTE   = 3'd2;
    localparam logic [2:0] ACT_TICK      = 3'd3;
    localparam logic [2:0] ACT_ROW_READ  = 3'd4;

    // Instruction groups (top nibble).
    localparam logic [3:0] OPG_SYS   = 4'h0;
    localparam logic [3:0] OPG_JUMP  = 4'h1;
    localparam logic [3:0] OPG_CALL  = 4'h2;
    localparam logic [3:0] OPG_SEQ   = 4'h3;
    localparam logic [3:0] OPG_SNE   = 4'h4;
    localparam logic [3:0] OPG_SREQ  = 4'h5;
    localparam logic [3:0] OPG_LDN   = 4'h6;
    localparam logic [3:0] OPG_ADDN  = 4'h7;
    localparam logic [3:0] OPG_ALU   = 4'h8;
    localparam logic [3:0] OPG_SRNE  = 4'h9;
    localparam logic [3:0] OPG_LDI   = 4'hA;
    localparam logic [3:0] OPG_DRAW  = 4'hD;
    localparam logic [3:0] OPG_MISC  = 4'hF;

    localparam logic [3:0] SYS_CLS = 4'h0;
    localparam logic [3:0] SYS_RET = 4'hE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] MISC_GET_DT = 8'h07;
    localparam logic [7:0] MISC_SET_DT = 8'h15;
    localparam logic [7:0] MISC_SET_ST = 8'h18;
    localparam logic [7:0] MISC_ADD_I  = 8'h1E;
    localparam logic [7:0] MISC_BCD    = 8'h33;
    localparam logic [7:0] MISC_STORE  = 8'h55;
    localparam logic [7:0] MISC_LOAD   = 8'h65;

    localparam logic [3:0] FLAG_REG = 4'hF;
    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] address;
        logic [7:0]  data;
        logic [4:0]  row;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [63:0] row_pixels;
        logic [11:0] program_counter;
        logic [15:0] last_opcode;
        logic        halted;
        logic [7:0]  delay_value;
        logic        sound_on;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISPATCH, S_RDWAIT, S_ROWWAIT, S_F1, S_F2, S_RX, S_RY,
        S_EXEC, S_RETW, S_DRAW, S_BCD, S_ST, S_LD, S_VF, S_DONE
    } t_state;

    typedef enum logic [5:0] {
        C_NONE, C_CLR_STEP, C_LATCH, C_MEM_WRITE, C_MEM_READ, C_CAP_READ,
        C_ROW_READ, C_CAP_ROW, C_FETCH_HI, C_FETCH_LO, C_OP_LATCH, C_CAP_VX,
        C_CAP_VY, C_HALT, C_TICK, C_CLS, C_RET_RD, C_RET_PC, C_JUMP, C_CALL,
        C_SKIP, C_SET_VX_NN, C_ADD_VX_NN, C_ALU, C_SET_I, C_DRAW_START,
        C_DRAW_STEP, C_SET_VX_DT, C_SET_DT, C_SET_ST, C_ADD_I, C_BCD_STEP,
        C_ST_START, C_ST_STEP, C_LD_START, C_LD_STEP, C_WRITE_VF, C_RESULT
    } t_cmd;

    typedef struct packed {
        logic        clr_done;
        logic        out_free;
        logic        halted;
        logic [2:0]  action;
        logic [15:0] opcode;
        logic        sp_zero;
        logic        sp_full;
        logic        draw_last;
        logic        cnt_eq_x;
        logic        bcd_last;
    } t_status;

endpackage
`default_nettype wire

FILE: hw/rtl/sprite_vm_instruction_core.sv
// Channel   Valid        Stall         Payload
// input     i_in_valid   o_in_stall    i_in_beat  (svm_pkg::t_in_beat)
// output    o_out_valid  i_out_stall   o_out_beat (svm_pkg::t_out_beat)
//
// After reset the core sweeps main memory and the register file to zero, one
// byte a cycle, and holds o_in_stall high meanwhile.
// Each beat is latched, dispatched and finished in turn, and the next beat is only
// accepted once the last one is done. An instruction fetches its two bytes, then reads
// its two registers and executes; sprite rows, stored registers, loaded registers and
// decimal digits are then handled one at a time.
// This sequencing is set by the single read port of main memory and the register file.
// A finished result waits in the output register while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_vm_instruction_core_defines.svh"
module sprite_vm_instruction_core #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire svm_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output svm_pkg::t_out_beat      o_out_beat
);

    // The controller sequences each beat; the datapath holds every store
    // (main memory, frame rows, registers, return stack) and executes one
    // command per cycle.
    svm_pkg::t_cmd    w_cmd;
    svm_pkg::t_state  w_state;
    svm_pkg::t_status w_status;

    svm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_state    (w_state),
        .o_in_stall (o_in_stall)
    );

    svm_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_beat   (i_in_beat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .o_status    (w_status)
    );

    // An accepted beat keeps the core busy on the following cycle.
    `SVM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "core idle right after accepting a beat")
    // Once halted, execution stays stopped until reset.
    `SVM_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, w_status.halted, w_status.halted, "halt flag cleared without reset")
    // No beat is taken while the memory clearing sweep runs.
    `SVM_ASSERT(a_clear_blocks, i_clk, i_rst_n, (w_state != svm_pkg::S_CLR) || o_in_stall, "input open during memory clear")

endmodule
`default_nettype wire

FILE: hw/rtl/svm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module svm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire svm_pkg::t_status i_status,
    output svm_pkg::t_cmd         o_cmd,
    output svm_pkg::t_state       o_state,
    output logic                  o_in_stall
);

    svm_pkg::t_state r_state;
    svm_pkg::t_state n_state;
    logic [3:0] w_grp;
    logic [3:0] w_n;
    logic [7:0] w_nn;

    assign w_grp = i_status.opcode[15:12];
    assign w_n   = i_status.opcode[3:0];
    assign w_nn  = i_status.opcode[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svm_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            svm_pkg::S_CLR: begin
                if (i_status.clr_done) n_state = svm_pkg::S_IDLE;
            end
            svm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = svm_pkg::S_DISPATCH;
            end
            svm_pkg::S_DISPATCH: begin
                case (i_status.action)
                    svm_pkg::ACT_MEM_READ: n_state = svm_pkg::S_RDWAIT;
                    svm_pkg::ACT_ROW_READ: n_state = svm_pkg::S_ROWWAIT;
                    svm_pkg::ACT_EXECUTE:
                        n_state = i_status.halted ? svm_pkg::S_DONE : svm_pkg::S_F1;
                    default: n_state = svm_pkg::S_DONE;
                endcase
            end
            svm_pkg::S_RDWAIT:  n_state = svm_pkg::S_DONE;
            svm_pkg::S_ROWWAIT: n_state = svm_pkg::S_DONE;
            svm_pkg::S_F1:      n_state = svm_pkg::S_F2;
            svm_pkg::S_F2:      n_state = svm_pkg::S_RX;
            svm_pkg::S_RX:      n_state = svm_pkg::S_RY;
            svm_pkg::S_RY:      n_state = svm_pkg::S_EXEC;
            svm_pkg::S_EXEC: begin
                n_state = svm_pkg::S_DONE;
                case (w_grp)
                    svm_pkg::OPG_SYS: begin
                        if (w_n == svm_pkg::SYS_RET && !i_status.sp_zero)
                            n_state = svm_pkg::S_RETW;
                    end
                    svm_pkg::OPG_ALU: begin
                        if (w_n inside {svm_pkg::ALU_ADD, svm_pkg::ALU_SUB, svm_pkg::ALU_SHR,
                                        svm_pkg::ALU_RSB, svm_pkg::ALU_SHL})
                            n_state = svm_pkg::S_VF;
                    end
                    svm_pkg::OPG_DRAW:
                        n_state = (w_n == 4'h0) ? svm_pkg::S_VF : svm_pkg::S_DRAW;
                    svm_pkg::OPG_MISC: begin
                        case (w_nn)
                            svm_pkg::MISC_BCD:   n_state = svm_pkg::S_BCD;
                            svm_pkg::MISC_STORE: n_state = svm_pkg::S_ST;
                            svm_pkg::MISC_LOAD:  n_state = svm_pkg::S_LD;
                            default:             n_state = svm_pkg::S_DONE;
                        endcase
                    end
                    default: n_state = svm_pkg::S_DONE;
                endcase
            end
            svm_pkg::S_RETW: n_state = svm_pkg::S_DONE;
            svm_pkg::S_DRAW: begin
                if (i_status.draw_last) n_state = svm_pkg::S_VF;
            end
            svm_pkg::S_BCD: begin
                if (i_status.bcd_last) n_state = svm_pkg::S_DONE;
            end
            svm_pkg::S_ST: begin
                if (i_status.cnt_eq_x) n_state = svm_pkg::S_DONE;
            end
            svm_pkg::S_LD: begin
                if (i_status.cnt_eq_x) n_state = svm_pkg::S_DONE;
            end
            svm_pkg::S_VF: n_state = svm_pkg::S_DONE;
            svm_pkg::S_DONE: begin
                if (i_status.out_free) n_state = svm_pkg::S_IDLE;
            end
            default: n_state = svm_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = svm_pkg::C_NONE;
        case (r_state)
            svm_pkg::S_CLR: o_cmd = svm_pkg::C_CLR_STEP;
            svm_pkg::S_IDLE: begin
                if (i_in_valid) o_cmd = svm_pkg::C_LATCH;
            end
            svm_pkg::S_DISPATCH: begin
                case (i_status.action)
                    svm_pkg::ACT_MEM_WRITE: o_cmd = svm_pkg::C_MEM_WRITE;
                    svm_pkg::ACT_MEM_READ:  o_cmd = svm_pkg::C_MEM_READ;
                    svm_pkg::ACT_EXECUTE:
                        o_cmd = i_status.halted ? svm_pkg::C_NONE : svm_pkg::C_FETCH_HI;
                    svm_pkg::ACT_TICK:      o_cmd = svm_pkg::C_TICK;
                    svm_pkg::ACT_ROW_READ:  o_cmd = svm_pkg::C_ROW_READ;
                    default:                o_cmd = svm_pkg::C_HALT;
                endcase
            end
            svm_pkg::S_RDWAIT:  o_cmd = svm_pkg::C_CAP_READ;
            svm_pkg::S_ROWWAIT: o_cmd = svm_pkg::C_CAP_ROW;
            svm_pkg::S_F1:      o_cmd = svm_pkg::C_FETCH_LO;
            svm_pkg::S_F2:      o_cmd = svm_pkg::C_OP_LATCH;
            svm_pkg::S_RX:      o_cmd = svm_pkg::C_CAP_VX;
            svm_pkg::S_RY:      o_cmd = svm_pkg::C_CAP_VY;
            svm_pkg::S_EXEC: begin
                case (w_grp)
                    svm_pkg::OPG_SYS: begin
                        if (w_n == svm_pkg::SYS_CLS) o_cmd = svm_pkg::C_CLS;
                        else if (w_n == svm_pkg::SYS_RET && !i_status.sp_zero)
                            o_cmd = svm_pkg::C_RET_RD;
                        else o_cmd = svm_pkg::C_HALT;
                    end
                    svm_pkg::OPG_JUMP: o_cmd = svm_pkg::C_JUMP;
                    svm_pkg::OPG_CALL:
                        o_cmd = i_status.sp_full ? svm_pkg::C_HALT : svm_pkg::C_CALL;
                    svm_pkg::OPG_SEQ, svm_pkg::OPG_SNE, svm_pkg::OPG_SREQ, svm_pkg::OPG_SRNE:
                        o_cmd = svm_pkg::C_SKIP;
                    svm_pkg::OPG_LDN:  o_cmd = svm_pkg::C_SET_VX_NN;
                    svm_pkg::OPG_ADDN: o_cmd = svm_pkg::C_ADD_VX_NN;
                    svm_pkg::OPG_ALU: begin
                        if (w_n inside {[svm_pkg::ALU_MOV:svm_pkg::ALU_RSB], svm_pkg::ALU_SHL})
                            o_cmd = svm_pkg::C_ALU;
                        else o_cmd = svm_pkg::C_HALT;
                    end
                    svm_pkg::OPG_LDI:  o_cmd = svm_pkg::C_SET_I;
                    svm_pkg::OPG_DRAW: o_cmd = svm_pkg::C_DRAW_START;
                    svm_pkg::OPG_MISC: begin
                        case (w_nn)
                            svm_pkg::MISC_GET_DT: o_cmd = svm_pkg::C_SET_VX_DT;
                            svm_pkg::MISC_SET_DT: o_cmd = svm_pkg::C_SET_DT;
                            svm_pkg::MISC_SET_ST: o_cmd = svm_pkg::C_SET_ST;
                            svm_pkg::MISC_ADD_I:  o_cmd = svm_pkg::C_ADD_I;
                            svm_pkg::MISC_BCD:    o_cmd = svm_pkg::C_NONE;
                            svm_pkg::MISC_STORE:  o_cmd = svm_pkg::C_ST_START;
                            svm_pkg::MISC_LOAD:   o_cmd = svm_pkg::C_LD_START;
                            default:              o_cmd = svm_pkg::C_HALT;
                        endcase
                    end
                    default: o_cmd = svm_pkg::C_HALT;
                endcase
            end
            svm_pkg::S_RETW: o_cmd = svm_pkg::C_RET_PC;
            svm_pkg::S_DRAW: o_cmd = svm_pkg::C_DRAW_STEP;
            svm_pkg::S_BCD:  o_cmd = svm_pkg::C_BCD_STEP;
            svm_pkg::S_ST:   o_cmd = svm_pkg::C_ST_STEP;
            svm_pkg::S_LD:   o_cmd = svm_pkg::C_LD_STEP;
            svm_pkg::S_VF:   o_cmd = svm_pkg::C_WRITE_VF;
            svm_pkg::S_DONE: begin
                if (i_status.out_free) o_cmd = svm_pkg::C_RESULT;
            end
            default: o_cmd = svm_pkg::C_NONE;
        endcase
    end

    assign o_state    = r_state;
    assign o_in_stall = (r_state != svm_pkg::S_IDLE);

endmodule
`default_nettype wire

FILE: hw/rtl/svm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module svm_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire svm_pkg::t_cmd     i_cmd,
    input  wire svm_pkg::t_in_beat i_in_beat,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output svm_pkg::t_out_beat     o_out_beat,
    output svm_pkg::t_status       o_status
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int AW     = svm_pkg::ADDR_W;
    localparam int RW     = svm_pkg::ROW_W;

    // Storage.
    logic [7:0]                  r_mem [svm_pkg::MEM_BYTES];
    logic [svm_pkg::SCREEN_W-1:0] r_frame [svm_pkg::SCREEN_H];
    logic [svm_pkg::SCREEN_H-1:0] r_fvalid;
    logic [7:0]                  r_regs [16];
    logic [AW-1:0]               r_stack [STACK_DEPTH];

    // Architectural and sequencing registers.
    svm_pkg::t_in_beat  r_in;
    svm_pkg::t_out_beat r_out_beat;
    logic               r_out_valid;
    logic [AW-1:0]      r_pc;
    logic [15:0]        r_op;
    logic [15:0]        r_i;
    logic [SP_W-1:0]    r_sp;
    logic [7:0]         r_dt;
    logic [7:0]         r_st;
    logic               r_halt;
    logic [AW-1:0]      r_clr_cnt;
    logic [4:0]         r_cnt;
    logic [7:0]         r_hi;
    logic [7:0]         r_vx;
    logic [7:0]         r_vy;
    logic               r_flag;
    logic [7:0]         r_res_rd;
    logic [63:0]        r_res_pix;
    logic [7:0]         r_mem_q;
    logic [63:0]        r_frm_q;
    logic               r_frm_v;
    logic [7:0]         r_reg_q;
    logic [AW-1:0]      r_stk_q;

    // Port controls.
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]    w_mem_wdata;
    logic [AW-1:0] w_mem_raddr;
    logic          w_reg_we;
    logic [3:0]    w_reg_waddr;
    logic [7:0]    w_reg_wdata;
    logic [3:0]    w_reg_raddr;
    logic [RW-1:0] w_frm_raddr;

    // Decoded fields and helpers.
    logic [3:0]    w_x;
    logic [3:0]    w_n;
    logic [7:0]    w_nn;
    logic [AW-1:0] w_nnn;
    logic [AW-1:0] w_loop_addr;
    logic [AW-1:0] w_loop_next;
    logic [4:0]    w_cnt_p1;
    logic [RW-1:0] w_draw_row;
    logic [63:0]   w_spr;
    logic [63:0]   w_cur;
    logic          w_hit;
    logic          w_skip;
    logic [7:0]    w_alu;
    logic          w_alu_f;
    logic [8:0]    w_sum;
    logic [8:0]    w_dif;
    logic [8:0]    w_rdif;
    logic [11:0]   w_bcd;
    logic [7:0]    w_digit;
    logic [SIDX_W-1:0] w_sp_idx;
    logic [SIDX_W-1:0] w_sp_dec;
    logic [SP_W-1:0]   w_sp_m1;

    // Three decimal digits of a byte, hundreds in the top nibble.
    function automatic logic [11:0] bcd3(input logic [7:0] v);
        logic [1:0] h;
        logic [6:0] rem;
        logic [3:0] t;
        logic [6:0] o;
        h   = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem = 7'(v - 8'(h) * 8'd100);
        t   = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (rem >= 7'(k * 10)) t = 4'(k);
        end
        o = 7'(rem - 7'(t) * 7'd10);
        return {2'b00, h, t, o[3:0]};
    endfunction

    assign w_x    = r_op[11:8];
    assign w_n    = r_op[3:0];
    assign w_nn   = r_op[7:0];
    assign w_nnn  = r_op[11:0];
    assign w_cnt_p1    = r_cnt + 5'd1;
    assign w_loop_addr = r_i[AW-1:0] + AW'(r_cnt);
    assign w_loop_next = r_i[AW-1:0] + AW'(w_cnt_p1);
    assign w_draw_row  = r_vy[RW-1:0] + r_cnt[RW-1:0];
    assign w_spr  = {r_mem_q, 56'd0} >> r_vx[svm_pkg::COL_W-1:0];
    assign w_cur  = r_frm_v ? r_frm_q : 64'd0;
    assign w_hit  = |(w_cur & w_spr);
    assign w_sum  = {1'b0, r_vx} + {1'b0, r_vy};
    assign w_dif  = {1'b0, r_vx} - {1'b0, r_vy};
    assign w_rdif = {1'b0, r_vy} - {1'b0, r_vx};
    assign w_bcd  = bcd3(r_vx);
    assign w_sp_m1  = r_sp - SP_W'(1);
    assign w_sp_idx = r_sp[SIDX_W-1:0];
    assign w_sp_dec = w_sp_m1[SIDX_W-1:0];

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_digit = {4'd0, w_bcd[11:8]};
            2'd1:    w_digit = {4'd0, w_bcd[7:4]};
            default: w_digit = {4'd0, w_bcd[3:0]};
        endcase
    end

    always_comb begin
        case (r_op[15:12])
            svm_pkg::OPG_SEQ:  w_skip = (r_vx == w_nn);
            svm_pkg::OPG_SNE:  w_skip = (r_vx != w_nn);
            svm_pkg::OPG_SREQ: w_skip = (r_vx == r_vy);
            svm_pkg::OPG_SRNE: w_skip = (r_vx != r_vy);
            default:           w_skip = 1'b0;
        endcase
    end

    always_comb begin
        w_alu   = r_vy;
        w_alu_f = 1'b0;
        case (w_n)
            svm_pkg::ALU_MOV: w_alu = r_vy;
            svm_pkg::ALU_OR:  w_alu = r_vx | r_vy;
            svm_pkg::ALU_AND: w_alu = r_vx & r_vy;
            svm_pkg::ALU_XOR: w_alu = r_vx ^ r_vy;
            svm_pkg::ALU_ADD: begin
                w_alu = w_sum[7:0]; w_alu_f = w_sum[8];
            end
            svm_pkg::ALU_SUB: begin
                w_alu = w_dif[7:0]; w_alu_f = !w_dif[8];
            end
            svm_pkg::ALU_SHR: begin
                w_alu = {1'b0, r_vy[7:1]}; w_alu_f = r_vy[0];
            end
            svm_pkg::ALU_RSB: begin
                w_alu = w_rdif[7:0]; w_alu_f = !w_rdif[8];
            end
            svm_pkg::ALU_SHL: begin
                w_alu = {r_vy[6:0], 1'b0}; w_alu_f = r_vy[7];
            end
            default: w_alu = r_vy;
        endcase
    end

    // Port selection per command.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = w_loop_addr;
        w_mem_wdata = r_reg_q;
        w_mem_raddr = r_pc;
        w_reg_we    = 1'b0;
        w_reg_waddr = w_x;
        w_reg_wdata = w_alu;
        w_reg_raddr = w_x;
        w_frm_raddr = w_draw_row;
        case (i_cmd)
            svm_pkg::C_CLR_STEP: begin
                // The sweep also zeroes the register file on its way.
                w_mem_we = 1'b1; w_mem_waddr = r_clr_cnt; w_mem_wdata = 8'd0;
                w_reg_we = 1'b1; w_reg_waddr = r_clr_cnt[3:0]; w_reg_wdata = 8'd0;
            end
            svm_pkg::C_MEM_WRITE: begin
                w_mem_we = 1'b1; w_mem_waddr = r_in.address; w_mem_wdata = r_in.data;
            end
            svm_pkg::C_MEM_READ:   w_mem_raddr = r_in.address;
            svm_pkg::C_FETCH_HI:   w_mem_raddr = r_pc;
            svm_pkg::C_FETCH_LO:   w_mem_raddr = r_pc + AW'(1);
            svm_pkg::C_ROW_READ:   w_frm_raddr = r_in.row;
            svm_pkg::C_OP_LATCH:   w_reg_raddr = r_hi[3:0];
            svm_pkg::C_CAP_VX:     w_reg_raddr = r_op[7:4];
            svm_pkg::C_SET_VX_NN: begin
                w_reg_we = 1'b1; w_reg_wdata = w_nn;
            end
            svm_pkg::C_ADD_VX_NN: begin
                w_reg_we = 1'b1; w_reg_wdata = r_vx + w_nn;
            end
            svm_pkg::C_ALU:        w_reg_we = 1'b1;
            svm_pkg::C_SET_VX_DT: begin
                w_reg_we = 1'b1; w_reg_wdata = r_dt;
            end
            svm_pkg::C_WRITE_VF: begin
                w_reg_we = 1'b1; w_reg_waddr = svm_pkg::FLAG_REG;
                w_reg_wdata = {7'd0, r_flag};
            end
            svm_pkg::C_DRAW_START: begin
                w_mem_raddr = w_loop_addr; w_frm_raddr = w_draw_row;
            end
            svm_pkg::C_DRAW_STEP: begin
                w_mem_raddr = w_loop_next; w_frm_raddr = w_draw_row + RW'(1);
            end
            svm_pkg::C_BCD_STEP: begin
                w_mem_we = 1'b1; w_mem_wdata = w_digit;
            end
            svm_pkg::C_ST_START:   w_reg_raddr = r_cnt[3:0];
            svm_pkg::C_ST_STEP: begin
                w_mem_we = 1'b1; w_reg_raddr = r_cnt[3:0] + 4'd1;
            end
            svm_pkg::C_LD_START:   w_mem_raddr = w_loop_addr;
            svm_pkg::C_LD_STEP: begin
                w_mem_raddr = w_loop_next; w_reg_we = 1'b1;
                w_reg_waddr = r_cnt[3:0]; w_reg_wdata = r_mem_q;
            end
            default: w_mem_we = 1'b0;
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_waddr] <= w_mem_wdata;
        r_mem_q <= r_mem[w_mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == svm_pkg::C_DRAW_STEP) r_frame[w_draw_row] <= w_cur ^ w_spr;
        r_frm_q <= r_frame[w_frm_raddr];
        r_frm_v <= r_fvalid[w_frm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_reg_we) r_regs[w_reg_waddr] <= w_reg_wdata;
        r_reg_q <= r_regs[w_reg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == svm_pkg::C_CALL) r_stack[w_sp_idx] <= r_pc;
        r_stk_q <= r_stack[w_sp_dec];
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pc        <= svm_pkg::PC_RESET;
            r_op        <= 16'd0;
            r_i         <= 16'd0;
            r_sp        <= '0;
            r_dt        <= 8'd0;
            r_st        <= 8'd0;
            r_halt      <= 1'b0;
            r_clr_cnt   <= '0;
            r_fvalid    <= '0;
        end else begin
            if (i_cmd == svm_pkg::C_RESULT) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            case (i_cmd)
                svm_pkg::C_CLR_STEP: r_clr_cnt <= r_clr_cnt + AW'(1);
                svm_pkg::C_OP_LATCH: begin
                    r_op <= {r_hi, r_mem_q};
                    r_pc <= r_pc + AW'(2);
                end
                svm_pkg::C_HALT: r_halt <= 1'b1;
                svm_pkg::C_TICK: begin
                    if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                    if (r_st != 8'd0) r_st <= r_st - 8'd1;
                end
                svm_pkg::C_CLS:    r_fvalid <= '0;
                svm_pkg::C_RET_RD: r_sp <= w_sp_m1;
                svm_pkg::C_RET_PC: r_pc <= r_stk_q;
                svm_pkg::C_JUMP:   r_pc <= w_nnn;
                svm_pkg::C_CALL: begin
                    r_sp <= r_sp + SP_W'(1);
                    r_pc <= w_nnn;
                end
                svm_pkg::C_SKIP: begin
                    if (w_skip) r_pc <= r_pc + AW'(2);
                end
                svm_pkg::C_SET_I:     r_i <= {4'd0, w_nnn};
                svm_pkg::C_DRAW_STEP: r_fvalid[w_draw_row] <= 1'b1;
                svm_pkg::C_SET_DT:    r_dt <= r_vx;
                svm_pkg::C_SET_ST:    r_st <= r_vx;
                svm_pkg::C_ADD_I:     r_i <= r_i + {8'd0, r_vx};
                default:              r_halt <= r_halt;
            endcase
        end
    end

    // Beat payload and working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            svm_pkg::C_LATCH: begin
                r_in      <= i_in_beat;
                r_cnt     <= 5'd0;
                r_res_rd  <= 8'd0;
                r_res_pix <= 64'd0;
            end
            svm_pkg::C_CAP_READ:   r_res_rd <= r_mem_q;
            svm_pkg::C_CAP_ROW:    r_res_pix <= w_cur;
            svm_pkg::C_FETCH_LO:   r_hi <= r_mem_q;
            svm_pkg::C_CAP_VX:     r_vx <= r_reg_q;
            svm_pkg::C_CAP_VY:     r_vy <= r_reg_q;
            svm_pkg::C_ALU:        r_flag <= w_alu_f;
            svm_pkg::C_DRAW_START: r_flag <= 1'b0;
            svm_pkg::C_DRAW_STEP: begin
                r_flag <= r_flag | w_hit;
                r_cnt  <= w_cnt_p1;
            end
            svm_pkg::C_BCD_STEP, svm_pkg::C_ST_STEP, svm_pkg::C_LD_STEP: r_cnt <= w_cnt_p1;
            svm_pkg::C_RESULT: begin
                r_out_beat.read_data       <= r_res_rd;
                r_out_beat.row_pixels      <= r_res_pix;
                r_out_beat.program_counter <= r_pc;
                r_out_beat.last_opcode     <= r_op;
                r_out_beat.halted          <= r_halt;
                r_out_beat.delay_value     <= r_dt;
                r_out_beat.sound_on        <= (r_st != 8'd0);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_comb begin
        o_status.clr_done  = (r_clr_cnt == AW'(svm_pkg::MEM_BYTES - 1));
        o_status.out_free  = !r_out_valid || !i_out_stall;
        o_status.halted    = r_halt;
        o_status.action    = r_in.action;
        o_status.opcode    = r_op;
        o_status.sp_zero   = (r_sp == '0);
        o_status.sp_full   = (r_sp >= SP_W'(STACK_DEPTH));
        o_status.draw_last = (w_cnt_p1 == {1'b0, w_n})
                           || (({1'b0, r_vy[RW-1:0]} + {1'b0, r_cnt[RW-1:0]}) >= 6'd31);
        o_status.cnt_eq_x  = (r_cnt == {1'b0, w_x});
        o_status.bcd_last  = (r_cnt == 5'd2);
    end

endmodule
`default_nettype wire

FILE: tb/tb_sprite_vm_instruction_core.sv
`timescale 1ns / 1ps
module tb_sprite_vm_instruction_core;
    import svm_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [2:0] ACT_BAD_FIRST = 3'd5;

    // The clock runs free; reset is held low at the start and then released.
    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_beat i_in_beat;
    logic o_out_valid;
    logic i_out_stall;
    t_out_beat o_out_beat;

    sprite_vm_instruction_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_beat(i_in_beat),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_beat(o_out_beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Our own copy of the machine. It is advanced once for every beat the
    // core accepts, so it always shows the state the next beat will see.
    logic [7:0]  vm_mem [MEM_BYTES];
    logic [63:0] vm_screen [SCREEN_H];
    logic [7:0]  vm_v [16];
    logic [15:0] vm_index;
    logic [11:0] vm_pc;
    logic [11:0] vm_stack [STACK_DEPTH];
    int          vm_depth;
    logic [7:0]  vm_delay;
    logic [7:0]  vm_sound;
    logic        vm_halted;
    logic [15:0] vm_opcode;

    // Results the core still owes us, oldest first.
    t_out_beat owed_results [$];

    int idle_pct;
    int stall_pct;
    int mismatches = 0;
    bit failed = 1'b0;
    int cycle_count = 0;

    // Runs one instruction against the model state. A halted core ignores it.
    task automatic run_instruction();
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, f;
        logic [11:0] nnn, a;
        logic [63:0] spr;
        logic [5:0]  col;
        int          top;
        logic        hit;
        if (vm_halted) return;
        op = {vm_mem[vm_pc], vm_mem[vm_pc + 12'd1]};
        vm_opcode = op;
        vm_pc = vm_pc + 12'd2;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        nnn = op[11:0];
        vx = vm_v[x];
        vy = vm_v[y];
        case (op[15:12])
            OPG_SYS: begin
                if (n == SYS_CLS) begin
                    foreach (vm_screen[r]) vm_screen[r] = '0;
                end else if (n == SYS_RET) begin
                    // Returning with nothing on the stack is a fault.
                    if (vm_depth == 0) begin
                        vm_halted = 1'b1;
                    end else begin
                        vm_depth--;
                        vm_pc = vm_stack[vm_depth];
                    end
                end else begin
                    vm_halted = 1'b1;
                end
            end
            OPG_JUMP: vm_pc = nnn;
            OPG_CALL: begin
                // A call into a full stack halts and does not jump.
                if (vm_depth >= STACK_DEPTH) begin
                    vm_halted = 1'b1;
                end else begin
                    vm_stack[vm_depth] = vm_pc;
                    vm_depth++;
                    vm_pc = nnn;
                end
            end
            OPG_SEQ:  if (vx == nn) vm_pc = vm_pc + 12'd2;
            OPG_SNE:  if (vx != nn) vm_pc = vm_pc + 12'd2;
            OPG_SREQ: if (vx == vy) vm_pc = vm_pc + 12'd2;
            OPG_SRNE: if (vx != vy) vm_pc = vm_pc + 12'd2;
            OPG_LDN:  vm_v[x] = nn;
            OPG_ADDN: vm_v[x] = vx + nn;
            OPG_ALU: begin
                // The flag register is written after the result register.
                case (n)
                    ALU_MOV: vm_v[x] = vy;
                    ALU_OR:  vm_v[x] = vx | vy;
                    ALU_AND: vm_v[x] = vx & vy;
                    ALU_XOR: vm_v[x] = vx ^ vy;
                    ALU_ADD: begin
                        f = ({1'b0, vx} + {1'b0, vy} > 9'd255) ? 8'd1 : 8'd0;
                        vm_v[x] = vx + vy;
                        vm_v[FLAG_REG] = f;
                    end
                    ALU_SUB: begin
                        f = (vx >= vy) ? 8'd1 : 8'd0;
                        vm_v[x] = vx - vy;
                        vm_v[FLAG_REG] = f;
                    end
                    ALU_SHR: begin
                        f = {7'd0, vy[0]};
                        vm_v[x] = vy >> 1;
                        vm_v[FLAG_REG] = f;
                    end
                    ALU_RSB: begin
                        f = (vy >= vx) ? 8'd1 : 8'd0;
                        vm_v[x] = vy - vx;
                        vm_v[FLAG_REG] = f;
                    end
                    ALU_SHL: begin
                        f = {7'd0, vy[7]};
                        vm_v[x] = vy << 1;
                        vm_v[FLAG_REG] = f;
                    end
                    default: vm_halted = 1'b1;
                endcase
            end
            OPG_LDI: vm_index = {4'd0, nnn};
            OPG_DRAW: begin
                // Rows past the bottom and pixels past the right edge are
                // clipped; the flag reports an erased lit pixel only.
                col = vx[5:0];
                top = vy[4:0];
                hit = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (top + i >= SCREEN_H) break;
                    a = vm_index[11:0] + 12'(i);
                    spr = {vm_mem[a], 56'd0} >> col;
                    if ((vm_screen[top + i] & spr) != 0) hit = 1'b1;
                    vm_screen[top + i] ^= spr;
                end
                vm_v[FLAG_REG] = {7'd0, hit};
            end
            OPG_MISC: begin
                case (nn)
                    MISC_GET_DT: vm_v[x] = vm_delay;
                    MISC_SET_DT: vm_delay = vx;
                    MISC_SET_ST: vm_sound = vx;
                    MISC_ADD_I:  vm_index = vm_index + {8'd0, vx};
                    MISC_BCD: begin
                        vm_mem[vm_index[11:0]] = vx / 8'd100;
                        vm_mem[vm_index[11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
                        vm_mem[vm_index[11:0] + 12'd2] = vx % 8'd10;
                    end
                    MISC_STORE:
                        for (int i = 0; i <= x; i++) vm_mem[vm_index[11:0] + 12'(i)] = vm_v[i];
                    MISC_LOAD:
                        for (int i = 0; i <= x; i++) vm_v[i] = vm_mem[vm_index[11:0] + 12'(i)];
                    default: vm_halted = 1'b1;
                endcase
            end
            default: vm_halted = 1'b1;
        endcase
    endtask

    // Applies one accepted beat to the model and returns the result it owes.
    task automatic advance_machine(input t_in_beat b, output t_out_beat res);
        res = '0;
        case (b.action)
            ACT_MEM_WRITE: vm_mem[b.address] = b.data;
            ACT_MEM_READ:  res.read_data = vm_mem[b.address];
            ACT_EXECUTE:   run_instruction();
            ACT_TICK: begin
                // Timers keep running while the core is halted.
                if (vm_delay != 0) vm_delay--;
                if (vm_sound != 0) vm_sound--;
            end
            ACT_ROW_READ:  res.row_pixels = vm_screen[b.row];
            default:       vm_halted = 1'b1;
        endcase
        res.program_counter = vm_pc;
        res.last_opcode = vm_opcode;
        res.halted = vm_halted;
        res.delay_value = vm_delay;
        res.sound_on = (vm_sound != 0);
    endtask

    // Offers one beat, after a random idle gap, and waits for it to be taken.
    // Valid stays high on return so that back-to-back beats need no toggle.
    task automatic send_beat(input logic [2:0] act, input logic [11:0] addr,
                             input logic [7:0] dat, input logic [4:0] rw);
        t_in_beat b;
        t_out_beat res;
        b = '{action: act, address: addr, data: dat, row: rw};
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= b;
        do @(posedge i_clk); while (o_in_stall);
        advance_machine(b, res);
        owed_results.push_back(res);
    endtask

    // Places an instruction word at the current program counter, then runs it.
    task automatic run_opcode(input logic [15:0] op);
        send_beat(ACT_MEM_WRITE, vm_pc, op[15:8], 5'($urandom));
        send_beat(ACT_MEM_WRITE, vm_pc + 12'd1, op[7:0], 5'($urandom));
        send_beat(ACT_EXECUTE, 12'($urandom), 8'($urandom), 5'($urandom));
    endtask

    // Draws a supported instruction that cannot fault in the current state.
    function automatic logic [15:0] pick_opcode();
        logic [3:0] x, y;
        logic [7:0] nn;
        logic [3:0] alu_ops [9];
        logic [7:0] misc_ops [7];
        alu_ops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                    ALU_RSB, ALU_SHL};
        misc_ops = '{MISC_GET_DT, MISC_SET_DT, MISC_SET_ST, MISC_ADD_I, MISC_BCD,
                     MISC_STORE, MISC_LOAD};
        x = 4'($urandom);
        y = 4'($urandom);
        nn = ($urandom_range(1) == 0) ? vm_v[x] : 8'($urandom);
        case ($urandom_range(19))
            0:      return {OPG_SYS, 8'($urandom), SYS_CLS};
            1, 2:   return (vm_depth > 0) ? {OPG_SYS, 8'($urandom), SYS_RET}
                                          : {OPG_LDN, x, nn};
            3:      return {OPG_JUMP, 12'($urandom)};
            4, 5:   return (vm_depth < STACK_DEPTH) ? {OPG_CALL, 12'($urandom)}
                                                    : {OPG_SYS, 8'($urandom), SYS_RET};
            6:      return {OPG_SEQ, x, nn};
            7:      return {OPG_SNE, x, nn};
            8:      return {OPG_SREQ, x, y, 4'($urandom)};
            9:      return {OPG_SRNE, x, y, 4'($urandom)};
            10:     return {OPG_LDN, x, nn};
            11:     return {OPG_ADDN, x, nn};
            12, 13: return {OPG_ALU, x, y, alu_ops[$urandom_range(8)]};
            14:     return {OPG_LDI, 12'($urandom)};
            15, 16: return {OPG_DRAW, x, y, 4'($urandom)};
            default: return {OPG_MISC, x, misc_ops[$urandom_range(6)]};
        endcase
    endfunction

    // Holds the sender until the core has returned every result it owes.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    // Memory and display extremes, timer ticks, a clipped draw that is then
    // erased, and an instruction fetched across the top of memory.
    task automatic test_directed();
        send_beat(ACT_MEM_READ, 12'hFFF, 8'h00, 5'd0);
        send_beat(ACT_MEM_WRITE, 12'hFFF, 8'hFF, 5'd31);
        send_beat(ACT_MEM_READ, 12'hFFF, 8'hFF, 5'd31);
        send_beat(ACT_MEM_WRITE, 12'hFF0, 8'hFF, 5'd0);
        send_beat(ACT_ROW_READ, 12'h000, 8'h00, 5'd31);
        send_beat(ACT_TICK, 12'h000, 8'h00, 5'd0);
        run_opcode({OPG_LDN, 4'h0, 8'h3F});
        run_opcode({OPG_LDN, 4'h1, 8'h1F});
        run_opcode({OPG_LDI, 12'hFF0});
        run_opcode({OPG_DRAW, 4'h0, 4'h1, 4'hF});
        send_beat(ACT_ROW_READ, 12'h000, 8'h00, 5'd31);
        run_opcode({OPG_DRAW, 4'h0, 4'h1, 4'h2});
        run_opcode({OPG_MISC, 4'h0, MISC_SET_DT});
        run_opcode({OPG_MISC, 4'h1, MISC_SET_ST});
        send_beat(ACT_TICK, 12'h000, 8'h00, 5'd0);
        run_opcode({OPG_JUMP, 12'hFFF});
        run_opcode({OPG_ADDN, 4'h2, 8'h01});
    endtask

    // Mostly well-formed instruction streams, with memory traffic, ticks
    // and display reads mixed in.
    task automatic test_random(input int beats, input int idle, input int stall);
        int sent;
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < beats) begin
            case ($urandom_range(99)) inside
                [0:54]: begin
                    run_opcode(pick_opcode());
                    sent += 2;
                end
                [55:64]: send_beat(ACT_MEM_WRITE, 12'($urandom), 8'($urandom),
                                   5'($urandom));
                [65:74]: send_beat(ACT_MEM_WRITE, vm_index[11:0] + 12'($urandom_range(15)),
                                   8'($urandom), 5'($urandom));
                [75:82]: send_beat(ACT_MEM_READ, ($urandom_range(1) == 0) ?
                                   12'($urandom) : vm_index[11:0] + 12'($urandom_range(15)),
                                   8'($urandom), 5'($urandom));
                [83:90]: send_beat(ACT_TICK, 12'($urandom), 8'($urandom), 5'($urandom));
                default: send_beat(ACT_ROW_READ, 12'($urandom), 8'($urandom),
                                   5'($urandom));
            endcase
            sent++;
        end
        drain_results();
    endtask

    // Halting is permanent, so it comes last: fill the call stack, overflow
    // it, then show that executes are ignored, timers still run and bad
    // action codes only keep the core halted.
    task automatic test_halting();
        idle_pct = 7;
        stall_pct = 7;
        run_opcode({OPG_LDN, 4'h5, 8'h09});
        run_opcode({OPG_MISC, 4'h5, MISC_SET_DT});
        run_opcode({OPG_MISC, 4'h5, MISC_SET_ST});
        while (vm_depth < STACK_DEPTH) run_opcode({OPG_CALL, 12'($urandom)});
        run_opcode({OPG_CALL, 12'($urandom)});
        run_opcode({OPG_LDN, 4'h0, 8'h00});
        for (int k = 0; k < 3; k++) begin
            send_beat(ACT_TICK, 12'($urandom), 8'($urandom), 5'($urandom));
            send_beat(ACT_BAD_FIRST + 3'(k), 12'($urandom), 8'($urandom), 5'($urandom));
        end
        send_beat(ACT_ROW_READ, 12'h000, 8'h00, 5'($urandom));
        send_beat(ACT_MEM_READ, vm_pc, 8'h00, 5'd0);
        drain_results();
    endtask

    // Receiver side: stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Every result beat is checked against the oldest one still owed.
    always @(posedge i_clk) begin
        t_out_beat want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("Result beat with none owed: %p", o_out_beat);
            end else begin
                want = owed_results.pop_front();
                if (o_out_beat.read_data !== want.read_data ||
                    o_out_beat.row_pixels !== want.row_pixels ||
                    o_out_beat.program_counter !== want.program_counter ||
                    o_out_beat.last_opcode !== want.last_opcode ||
                    o_out_beat.halted !== want.halted ||
                    o_out_beat.delay_value !== want.delay_value ||
                    o_out_beat.sound_on !== want.sound_on) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected %p", want);
                        $display("          actual   %p", o_out_beat);
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_beat <= '0;
        idle_pct = 0;
        stall_pct = 0;
        foreach (vm_mem[a]) vm_mem[a] = '0;
        foreach (vm_screen[r]) vm_screen[r] = '0;
        foreach (vm_v[r]) vm_v[r] = '0;
        vm_index = '0;
        vm_pc = PC_RESET;
        vm_depth = 0;
        vm_delay = '0;
        vm_sound = '0;
        vm_halted = 1'b0;
        vm_opcode = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The core clears its memory after reset; the first beat simply
        // waits on the stall until that sweep is over.
        test_directed();
        drain_results();
        test_random(325, 0, 0);
        test_random(325, 73, 0);
        test_random(325, 0, 73);
        test_random(325, 7, 7);
        test_halting();

        repeat (60) @(posedge i_clk);
        if (!failed && owed_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
